// File: rtl/vpcn_pkg.sv
package vpcn_pkg;

   localparam int unsigned ArgWidth = 32;
   localparam int unsigned NumArgs  = 7;

   localparam logic [7:0] LETTER_NONE = 8'h00;
   localparam logic [7:0] LETTER_M    = 8'h4D;
   localparam logic [7:0] LETTER_L    = 8'h4C;
   localparam logic [7:0] LETTER_H    = 8'h48;
   localparam logic [7:0] LETTER_V    = 8'h56;
   localparam logic [7:0] LETTER_C    = 8'h43;
   localparam logic [7:0] LETTER_S    = 8'h53;
   localparam logic [7:0] LETTER_Q    = 8'h51;
   localparam logic [7:0] LETTER_T    = 8'h54;
   localparam logic [7:0] LETTER_A    = 8'h41;
   localparam logic [7:0] LETTER_Z    = 8'h5A;
   localparam logic [7:0] LETTER_LC_M = 8'h6D;
   localparam logic [7:0] LETTER_LC_L = 8'h6C;
   localparam logic [7:0] LETTER_LC_A = 8'h61;
   localparam logic [7:0] LETTER_LC_Z = 8'h7A;
   localparam logic [7:0] CASE_OFFSET = 8'h20;

   localparam logic signed [ArgWidth-1:0] Q_MAX = {1'b0, {(ArgWidth-1){1'b1}}};
   localparam logic signed [ArgWidth-1:0] Q_MIN = {1'b1, {(ArgWidth-1){1'b0}}};

   typedef enum logic [2:0] {
      KIND_MOVE      = 3'd0,
      KIND_LINE      = 3'd1,
      KIND_CUBIC     = 3'd2,
      KIND_QUADRATIC = 3'd3,
      KIND_ARC       = 3'd4,
      KIND_CLOSE     = 3'd5
   } kind_type;

   typedef logic signed [ArgWidth-1:0] coord_type;

   // Saturating sum of two signed coordinates.
   function automatic coord_type sat_add(input coord_type a, input coord_type b);
      logic signed [ArgWidth:0] s;
      s = {a[ArgWidth-1], a} + {b[ArgWidth-1], b};
      if (s[ArgWidth] != s[ArgWidth-1]) begin
         return s[ArgWidth] ? Q_MIN : Q_MAX;
      end
      return s[ArgWidth-1:0];
   endfunction

   // Reflection of p about centre, 2*centre - p, saturated.
   function automatic coord_type sat_reflect(input coord_type centre, input coord_type p);
      logic signed [ArgWidth+1:0] r;
      r = {centre[ArgWidth-1], centre, 1'b0} - {{2{p[ArgWidth-1]}}, p};
      if ((r[ArgWidth+1] != r[ArgWidth]) || (r[ArgWidth] != r[ArgWidth-1])) begin
         return r[ArgWidth+1] ? Q_MIN : Q_MAX;
      end
      return r[ArgWidth-1:0];
   endfunction

endpackage

// File: rtl/vector_path_command_normalizer.sv
// Vector path command normalizer.
// The request channel (req_) carries one tokenized path command per request:
// a letter, or a flag meaning the previous command repeats, and seven signed
// Q16.16 arguments. The response channel (rsp_) returns one absolute command
// per request: move, line, cubic, quadratic, arc or close, with an error flag.
// A request is taken into an input register; combinational adders, a doubling
// and selection against the pen state produce the response register.
// A request passes the input register, then the response register. Without
// a stall the block sustains one request per cycle, as the pen state updates
// in the same cycle that a command moves into the response register.
// When the receiver stalls, the response register holds and the input
// register still takes one more request; req_tready then falls until the
// response is taken.
// Reset clears the pen, subpath start, control point, last letter and the
// sticky error, and empties both registers. Once an error is seen, every
// response reports it until the next reset.
module vector_path_command_normalizer (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // command[7:0], arg0[39:8], arg1[71:40], arg2[103:72], arg3[135:104],
   // arg4[167:136], arg5[199:168], arg6[231:200]
   input  logic [231:0] req_tdata,
   // has_letter[0]
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // v0[31:0], v1[63:32], v2[95:64], v3[127:96], v4[159:128], v5[191:160],
   // v6[223:192]
   output logic [223:0] rsp_tdata,
   // kind[2:0], error[3]
   output logic [3:0]   rsp_tuser
);
   import vpcn_pkg::*;

   logic      in_valid_ff;
   logic [7:0] in_command_ff;
   logic      in_has_letter_ff;
   coord_type in_arg_ff [NumArgs];

   coord_type pen_x_ff, pen_y_ff, start_x_ff, start_y_ff, ctrl_x_ff, ctrl_y_ff;
   coord_type pen_x_in, pen_y_in, start_x_in, start_y_in, ctrl_x_in, ctrl_y_in;
   logic [7:0] prev_letter_ff, prev_letter_in;
   logic      failed_ff, failed_in;

   logic      out_valid_ff;
   kind_type  out_kind_ff, out_kind_in;
   logic      out_error_ff, out_error_in;
   coord_type out_v_ff [NumArgs];
   coord_type out_v_in [NumArgs];

   logic      out_load;
   logic      fire;

   logic [7:0] letter;
   logic [7:0] up;
   logic      rel;
   logic      bad;
   logic      prev_cubic, prev_quad;
   coord_type ox, oy;
   coord_type c1x, c1y, c2x, c2y, end_x, end_y;

   assign out_load   = !out_valid_ff || rsp_tready;
   assign fire       = in_valid_ff && out_load;
   assign req_tready = !in_valid_ff || out_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_command_ff    <= req_tdata[7:0];
         in_has_letter_ff <= req_tuser;
         for (int i = 0; i < NumArgs; i++) begin
            in_arg_ff[i] <= req_tdata[8 + i*ArgWidth +: ArgWidth];
         end
      end
   end

   always_comb begin
      prev_cubic = (prev_letter_ff == LETTER_C) || (prev_letter_ff == LETTER_S) ||
                   (prev_letter_ff == (LETTER_C | CASE_OFFSET)) ||
                   (prev_letter_ff == (LETTER_S | CASE_OFFSET));
      prev_quad  = (prev_letter_ff == LETTER_Q) || (prev_letter_ff == LETTER_T) ||
                   (prev_letter_ff == (LETTER_Q | CASE_OFFSET)) ||
                   (prev_letter_ff == (LETTER_T | CASE_OFFSET));

      bad = 1'b0;
      if (in_has_letter_ff) begin
         letter = in_command_ff;
      end else begin
         letter = prev_letter_ff;
         if ((prev_letter_ff == LETTER_NONE) || (prev_letter_ff == LETTER_Z) ||
             (prev_letter_ff == LETTER_LC_Z)) begin
            bad = 1'b1;
         end else if (prev_letter_ff == LETTER_M) begin
            letter = LETTER_L;
         end else if (prev_letter_ff == LETTER_LC_M) begin
            letter = LETTER_LC_L;
         end
      end

      rel = (letter >= LETTER_LC_A) && (letter <= LETTER_LC_Z);
      up  = rel ? (letter - CASE_OFFSET) : letter;
      ox  = rel ? pen_x_ff : '0;
      oy  = rel ? pen_y_ff : '0;

      pen_x_in       = pen_x_ff;
      pen_y_in       = pen_y_ff;
      start_x_in     = start_x_ff;
      start_y_in     = start_y_ff;
      ctrl_x_in      = ctrl_x_ff;
      ctrl_y_in      = ctrl_y_ff;
      prev_letter_in = letter;
      failed_in      = failed_ff;
      out_kind_in    = KIND_MOVE;
      out_error_in   = 1'b0;
      for (int i = 0; i < NumArgs; i++) begin
         out_v_in[i] = '0;
      end
      c1x   = '0;
      c1y   = '0;
      c2x   = '0;
      c2y   = '0;
      end_x = '0;
      end_y = '0;

      unique case (up)
         LETTER_M, LETTER_L, LETTER_H, LETTER_V: begin
            end_x = (up == LETTER_V) ? pen_x_ff : sat_add(ox, in_arg_ff[0]);
            if (up == LETTER_H) begin
               end_y = pen_y_ff;
            end else if (up == LETTER_V) begin
               end_y = sat_add(oy, in_arg_ff[0]);
            end else begin
               end_y = sat_add(oy, in_arg_ff[1]);
            end
            out_kind_in = (up == LETTER_M) ? KIND_MOVE : KIND_LINE;
            out_v_in[0] = end_x;
            out_v_in[1] = end_y;
            if (up == LETTER_M) begin
               start_x_in = end_x;
               start_y_in = end_y;
            end
            pen_x_in  = end_x;
            pen_y_in  = end_y;
            ctrl_x_in = end_x;
            ctrl_y_in = end_y;
         end
         LETTER_C, LETTER_S: begin
            if (up == LETTER_C) begin
               c1x   = sat_add(ox, in_arg_ff[0]);
               c1y   = sat_add(oy, in_arg_ff[1]);
               c2x   = sat_add(ox, in_arg_ff[2]);
               c2y   = sat_add(oy, in_arg_ff[3]);
               end_x = sat_add(ox, in_arg_ff[4]);
               end_y = sat_add(oy, in_arg_ff[5]);
            end else begin
               if (prev_cubic) begin
                  c1x = sat_reflect(pen_x_ff, ctrl_x_ff);
                  c1y = sat_reflect(pen_y_ff, ctrl_y_ff);
               end else begin
                  c1x = pen_x_ff;
                  c1y = pen_y_ff;
               end
               c2x   = sat_add(ox, in_arg_ff[0]);
               c2y   = sat_add(oy, in_arg_ff[1]);
               end_x = sat_add(ox, in_arg_ff[2]);
               end_y = sat_add(oy, in_arg_ff[3]);
            end
            out_kind_in = KIND_CUBIC;
            out_v_in[0] = c1x;
            out_v_in[1] = c1y;
            out_v_in[2] = c2x;
            out_v_in[3] = c2y;
            out_v_in[4] = end_x;
            out_v_in[5] = end_y;
            pen_x_in    = end_x;
            pen_y_in    = end_y;
            ctrl_x_in   = c2x;
            ctrl_y_in   = c2y;
         end
         LETTER_Q, LETTER_T: begin
            if (up == LETTER_Q) begin
               c1x   = sat_add(ox, in_arg_ff[0]);
               c1y   = sat_add(oy, in_arg_ff[1]);
               end_x = sat_add(ox, in_arg_ff[2]);
               end_y = sat_add(oy, in_arg_ff[3]);
            end else begin
               if (prev_quad) begin
                  c1x = sat_reflect(pen_x_ff, ctrl_x_ff);
                  c1y = sat_reflect(pen_y_ff, ctrl_y_ff);
               end else begin
                  c1x = pen_x_ff;
                  c1y = pen_y_ff;
               end
               end_x = sat_add(ox, in_arg_ff[0]);
               end_y = sat_add(oy, in_arg_ff[1]);
            end
            out_kind_in = KIND_QUADRATIC;
            out_v_in[0] = c1x;
            out_v_in[1] = c1y;
            out_v_in[2] = end_x;
            out_v_in[3] = end_y;
            pen_x_in    = end_x;
            pen_y_in    = end_y;
            ctrl_x_in   = c1x;
            ctrl_y_in   = c1y;
         end
         LETTER_A: begin
            end_x       = sat_add(ox, in_arg_ff[5]);
            end_y       = sat_add(oy, in_arg_ff[6]);
            out_kind_in = KIND_ARC;
            out_v_in[0] = in_arg_ff[0];
            out_v_in[1] = in_arg_ff[1];
            out_v_in[2] = in_arg_ff[2];
            out_v_in[3] = {{(ArgWidth-1){1'b0}}, (in_arg_ff[3] != '0)};
            out_v_in[4] = {{(ArgWidth-1){1'b0}}, (in_arg_ff[4] != '0)};
            out_v_in[5] = end_x;
            out_v_in[6] = end_y;
            pen_x_in    = end_x;
            pen_y_in    = end_y;
            ctrl_x_in   = end_x;
            ctrl_y_in   = end_y;
         end
         LETTER_Z: begin
            out_kind_in = KIND_CLOSE;
            pen_x_in    = start_x_ff;
            pen_y_in    = start_y_ff;
            ctrl_x_in   = start_x_ff;
            ctrl_y_in   = start_y_ff;
         end
         default: begin
            bad = 1'b1;
         end
      endcase

      // A failure, now or earlier, leaves the pen state untouched.
      if (failed_ff || bad) begin
         pen_x_in       = pen_x_ff;
         pen_y_in       = pen_y_ff;
         start_x_in     = start_x_ff;
         start_y_in     = start_y_ff;
         ctrl_x_in      = ctrl_x_ff;
         ctrl_y_in      = ctrl_y_ff;
         prev_letter_in = prev_letter_ff;
         failed_in      = 1'b1;
         out_kind_in    = KIND_MOVE;
         out_error_in   = 1'b1;
         for (int i = 0; i < NumArgs; i++) begin
            out_v_in[i] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pen_x_ff       <= '0;
         pen_y_ff       <= '0;
         start_x_ff     <= '0;
         start_y_ff     <= '0;
         ctrl_x_ff      <= '0;
         ctrl_y_ff      <= '0;
         prev_letter_ff <= LETTER_NONE;
         failed_ff      <= 1'b0;
      end else if (fire) begin
         pen_x_ff       <= pen_x_in;
         pen_y_ff       <= pen_y_in;
         start_x_ff     <= start_x_in;
         start_y_ff     <= start_y_in;
         ctrl_x_ff      <= ctrl_x_in;
         ctrl_y_ff      <= ctrl_y_in;
         prev_letter_ff <= prev_letter_in;
         failed_ff      <= failed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_kind_ff  <= out_kind_in;
         out_error_ff <= out_error_in;
         for (int i = 0; i < NumArgs; i++) begin
            out_v_ff[i] <= out_v_in[i];
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = {out_error_ff, out_kind_ff};

   always_comb begin
      for (int i = 0; i < NumArgs; i++) begin
         rsp_tdata[i*ArgWidth +: ArgWidth] = out_v_ff[i];
      end
   end

endmodule

// File: tb/sv/vector_path_command_normalizer_tb.sv
module vector_path_command_normalizer_tb;

   import vpcn_pkg::*;

   localparam int IDLE_LIMIT   = 2000;
   localparam int RANDOM_ITEMS = 480;
   localparam int HOLD_AFTER   = 150;
   localparam int HOLD_CYCLES  = 90;

   typedef struct {
      logic [7:0] letter;
      logic       has_letter;
      coord_type  arg [NumArgs];
   } path_request_type;

   typedef struct {
      kind_type   kind;
      logic       error;
      coord_type  v [NumArgs];
   } path_command_type;

   // Tracks the pen exactly as the block should, and keeps the absolute
   // commands that are still owed on the response channel.
   class path_tracker_type;
      coord_type        pen_x = '0;
      coord_type        pen_y = '0;
      coord_type        start_x = '0;
      coord_type        start_y = '0;
      coord_type        ctrl_x = '0;
      coord_type        ctrl_y = '0;
      logic [7:0]       last_letter = LETTER_NONE;
      bit               failed = 1'b0;
      path_command_type pending_commands [$];
      int               responses_checked = 0;
      int               mismatches = 0;

      function coord_type clip(longint s);
         if (s > longint'(Q_MAX)) return Q_MAX;
         if (s < longint'(Q_MIN)) return Q_MIN;
         return coord_type'(s);
      endfunction

      function coord_type offset_sum(coord_type base, coord_type a);
         return clip(longint'(base) + longint'(a));
      endfunction

      function coord_type mirror(coord_type centre, coord_type p);
         return clip(2 * longint'(centre) - longint'(p));
      endfunction

      function void note_request(path_request_type r);
         path_command_type e;
         logic [7:0]       c, up;
         logic             rel, bad;
         coord_type        ox, oy, x, y, c1x, c1y, c2x, c2y;
         int               k;
         e.kind  = KIND_MOVE;
         e.error = 1'b0;
         foreach (e.v[i]) e.v[i] = '0;
         bad = failed;
         c = r.has_letter ? r.letter : last_letter;
         if (!bad && !r.has_letter) begin
            if (c == LETTER_NONE || c == LETTER_Z || c == LETTER_LC_Z) bad = 1'b1;
            else if (c == LETTER_M) c = LETTER_L;
            else if (c == LETTER_LC_M) c = LETTER_LC_L;
         end
         rel = (c >= LETTER_LC_A) && (c <= LETTER_LC_Z);
         up  = rel ? c - CASE_OFFSET : c;
         ox  = rel ? pen_x : '0;
         oy  = rel ? pen_y : '0;
         if (!bad) begin
            case (up)
               LETTER_M, LETTER_L, LETTER_H, LETTER_V: begin
                  x = (up == LETTER_V) ? pen_x : offset_sum(ox, r.arg[0]);
                  if (up == LETTER_H) y = pen_y;
                  else if (up == LETTER_V) y = offset_sum(oy, r.arg[0]);
                  else y = offset_sum(oy, r.arg[1]);
                  e.kind = (up == LETTER_M) ? KIND_MOVE : KIND_LINE;
                  e.v[0] = x;
                  e.v[1] = y;
                  if (up == LETTER_M) begin
                     start_x = x;
                     start_y = y;
                  end
                  pen_x = x;
                  pen_y = y;
                  ctrl_x = x;
                  ctrl_y = y;
               end
               LETTER_C, LETTER_S: begin
                  k = 0;
                  if (up == LETTER_C) begin
                     c1x = offset_sum(ox, r.arg[0]);
                     c1y = offset_sum(oy, r.arg[1]);
                     k = 2;
                  end else if ((last_letter | CASE_OFFSET) == (LETTER_C | CASE_OFFSET) ||
                               (last_letter | CASE_OFFSET) == (LETTER_S | CASE_OFFSET)) begin
                     c1x = mirror(pen_x, ctrl_x);
                     c1y = mirror(pen_y, ctrl_y);
                  end else begin
                     c1x = pen_x;
                     c1y = pen_y;
                  end
                  c2x = offset_sum(ox, r.arg[k]);
                  c2y = offset_sum(oy, r.arg[k + 1]);
                  x   = offset_sum(ox, r.arg[k + 2]);
                  y   = offset_sum(oy, r.arg[k + 3]);
                  e.kind = KIND_CUBIC;
                  e.v[0] = c1x;
                  e.v[1] = c1y;
                  e.v[2] = c2x;
                  e.v[3] = c2y;
                  e.v[4] = x;
                  e.v[5] = y;
                  pen_x = x;
                  pen_y = y;
                  ctrl_x = c2x;
                  ctrl_y = c2y;
               end
               LETTER_Q, LETTER_T: begin
                  k = 0;
                  if (up == LETTER_Q) begin
                     c1x = offset_sum(ox, r.arg[0]);
                     c1y = offset_sum(oy, r.arg[1]);
                     k = 2;
                  end else if ((last_letter | CASE_OFFSET) == (LETTER_Q | CASE_OFFSET) ||
                               (last_letter | CASE_OFFSET) == (LETTER_T | CASE_OFFSET)) begin
                     c1x = mirror(pen_x, ctrl_x);
                     c1y = mirror(pen_y, ctrl_y);
                  end else begin
                     c1x = pen_x;
                     c1y = pen_y;
                  end
                  x = offset_sum(ox, r.arg[k]);
                  y = offset_sum(oy, r.arg[k + 1]);
                  e.kind = KIND_QUADRATIC;
                  e.v[0] = c1x;
                  e.v[1] = c1y;
                  e.v[2] = x;
                  e.v[3] = y;
                  pen_x = x;
                  pen_y = y;
                  ctrl_x = c1x;
                  ctrl_y = c1y;
               end
               LETTER_A: begin
                  x = offset_sum(ox, r.arg[5]);
                  y = offset_sum(oy, r.arg[6]);
                  e.kind = KIND_ARC;
                  e.v[0] = r.arg[0];
                  e.v[1] = r.arg[1];
                  e.v[2] = r.arg[2];
                  e.v[3] = (r.arg[3] != 0) ? 32'sd1 : 32'sd0;
                  e.v[4] = (r.arg[4] != 0) ? 32'sd1 : 32'sd0;
                  e.v[5] = x;
                  e.v[6] = y;
                  pen_x = x;
                  pen_y = y;
                  ctrl_x = x;
                  ctrl_y = y;
               end
               LETTER_Z: begin
                  e.kind = KIND_CLOSE;
                  pen_x = start_x;
                  pen_y = start_y;
                  ctrl_x = start_x;
                  ctrl_y = start_y;
               end
               default: bad = 1'b1;
            endcase
         end
         if (bad) begin
            failed  = 1'b1;
            e.kind  = KIND_MOVE;
            e.error = 1'b1;
            foreach (e.v[i]) e.v[i] = '0;
         end else begin
            last_letter = c;
         end
         pending_commands.push_back(e);
      endfunction

      function void check_response(path_command_type got);
         path_command_type want;
         bit               differs;
         responses_checked++;
         if (pending_commands.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("response %0d arrived with nothing pending: kind %0d error %0b",
                        responses_checked, got.kind, got.error);
            return;
         end
         want = pending_commands.pop_front();
         differs = (got.kind !== want.kind) || (got.error !== want.error);
         foreach (want.v[i]) if (got.v[i] !== want.v[i]) differs = 1'b1;
         if (differs) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("response %0d mismatch, expected kind %0d error %0b v %h %h %h %h %h %h %h",
                        responses_checked, want.kind, want.error, want.v[0], want.v[1],
                        want.v[2], want.v[3], want.v[4], want.v[5], want.v[6]);
               $display("response %0d mismatch, actual   kind %0d error %0b v %h %h %h %h %h %h %h",
                        responses_checked, got.kind, got.error, got.v[0], got.v[1],
                        got.v[2], got.v[3], got.v[4], got.v[5], got.v[6]);
            end
         end
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [231:0] req_tdata = '0;
   logic         req_tuser = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [223:0] rsp_tdata;
   logic [3:0]   rsp_tuser;

   path_tracker_type tracker;
   logic [7:0]   path_letters [10] = '{LETTER_M, LETTER_L, LETTER_H, LETTER_V, LETTER_C,
                                       LETTER_S, LETTER_Q, LETTER_T, LETTER_A, LETTER_Z};
   bit           feed_steady = 1'b0;
   bit           sink_steady = 1'b0;
   int           responses_taken = 0;
   int           stall_left = 0;
   int           hold_left = 0;

   vector_path_command_normalizer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic coord_type q16(int whole);
      return coord_type'(whole <<< 16);
   endfunction

   // Mostly back to back, sometimes a short pause, now and then a long one.
   function automatic int pick_gap(bit steady);
      int roll;
      if (steady) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 45);
   endfunction

   function automatic coord_type random_arg();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return coord_type'($urandom_range(0, 200 << 16)) - q16(100);
      if (roll < 75) return coord_type'($urandom);
      if (roll < 90) begin
         case ($urandom_range(0, 3))
            0: return Q_MAX;
            1: return Q_MIN;
            2: return '0;
            default: return -32'sd1;
         endcase
      end
      if ($urandom_range(0, 1)) return Q_MAX - coord_type'($urandom_range(0, 50 << 16));
      return Q_MIN + coord_type'($urandom_range(0, 50 << 16));
   endfunction

   task automatic offer_command(input logic [7:0] letter, input logic has_letter,
                                input coord_type a0 = '0, input coord_type a1 = '0,
                                input coord_type a2 = '0, input coord_type a3 = '0,
                                input coord_type a4 = '0, input coord_type a5 = '0,
                                input coord_type a6 = '0);
      path_request_type r;
      int               gap;
      r.letter     = letter;
      r.has_letter = has_letter;
      r.arg[0] = a0;
      r.arg[1] = a1;
      r.arg[2] = a2;
      r.arg[3] = a3;
      r.arg[4] = a4;
      r.arg[5] = a5;
      r.arg[6] = a6;
      req_tdata  <= {a6, a5, a4, a3, a2, a1, a0, letter};
      req_tuser  <= has_letter;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      tracker.note_request(r);
      if ($urandom_range(0, 29) == 0) feed_steady = !feed_steady;
      gap = pick_gap(feed_steady);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drive_directed_path();
      offer_command(LETTER_M, 1'b1, q16(10), q16(20));
      // A repeated move turns into a line.
      offer_command(8'($urandom), 1'b0, Q_MAX, Q_MIN);
      offer_command(LETTER_LC_L, 1'b1, Q_MAX, Q_MAX);
      offer_command(LETTER_H | CASE_OFFSET, 1'b1, Q_MIN);
      offer_command(LETTER_H, 1'b1, q16(5));
      offer_command(LETTER_V | CASE_OFFSET, 1'b1, q16(-3));
      offer_command(LETTER_V, 1'b1, Q_MAX);
      offer_command(LETTER_C, 1'b1, q16(1), q16(2), q16(3), q16(4), q16(5), q16(6));
      offer_command(LETTER_S | CASE_OFFSET, 1'b1, q16(-7), q16(8), q16(9), q16(-10));
      offer_command(8'($urandom), 1'b0, q16(2), q16(2), q16(-4), q16(4));
      offer_command(LETTER_L, 1'b1, q16(-50), q16(60));
      // Smooth cubic after a line reuses the pen as its first control point.
      offer_command(LETTER_S, 1'b1, q16(11), q16(12), q16(13), q16(14));
      offer_command(LETTER_Q, 1'b1, q16(-1), q16(1), q16(20), q16(30));
      offer_command(LETTER_T | CASE_OFFSET, 1'b1, q16(7), q16(-7));
      offer_command(8'($urandom), 1'b0, Q_MIN, Q_MAX);
      offer_command(LETTER_M, 1'b1, q16(0), q16(0));
      offer_command(LETTER_T, 1'b1, q16(4), q16(5));
      offer_command(LETTER_A, 1'b1, q16(3), q16(2), q16(45), '0, '0, q16(8), q16(-8));
      offer_command(LETTER_LC_A, 1'b1, Q_MAX, Q_MIN, -32'sd1, Q_MIN, 32'sd1, Q_MAX, Q_MIN);
      offer_command(LETTER_LC_M, 1'b1, q16(100), q16(-100));
      offer_command(8'($urandom), 1'b0, q16(1), q16(1));
      offer_command(LETTER_LC_Z, 1'b1);
      offer_command(LETTER_Z, 1'b1);
      // Control point far from the end point so that the reflection saturates.
      offer_command(LETTER_C, 1'b1, '0, '0, Q_MIN, Q_MIN, Q_MAX, Q_MAX);
      offer_command(LETTER_S, 1'b1, q16(1), q16(1), q16(2), q16(2));
   endtask

   task automatic drive_random_path(input int count);
      coord_type  a [NumArgs];
      logic [7:0] letter, prev_up;
      logic       has_letter;
      for (int n = 0; n < count; n++) begin
         foreach (a[i]) a[i] = random_arg();
         if ($urandom_range(0, 1)) a[3] = '0;
         if ($urandom_range(0, 1)) a[4] = '0;
         prev_up = tracker.last_letter & ~CASE_OFFSET;
         has_letter = 1'b1;
         if (tracker.last_letter != LETTER_NONE && prev_up != LETTER_Z &&
             $urandom_range(0, 99) < 15) begin
            has_letter = 1'b0;
            letter = 8'($urandom);
         end else if ((prev_up == LETTER_C || prev_up == LETTER_S) && $urandom_range(0, 1)) begin
            letter = LETTER_S;
         end else if ((prev_up == LETTER_Q || prev_up == LETTER_T) && $urandom_range(0, 1)) begin
            letter = LETTER_T;
         end else begin
            letter = path_letters[$urandom_range(0, 9)];
         end
         if (has_letter && $urandom_range(0, 1)) letter = letter | CASE_OFFSET;
         offer_command(letter, has_letter, a[0], a[1], a[2], a[3], a[4], a[5], a[6]);
      end
   endtask

   // The error is sticky and reset comes only once, so this failing tail goes
   // last and the requests after the failing command must all report the error.
   task automatic drive_failure_tail();
      logic [7:0] code, up;
      bit         known;
      if ($urandom_range(0, 1)) begin
         do begin
            code = 8'($urandom);
            up = (code >= LETTER_LC_A && code <= LETTER_LC_Z) ? code - CASE_OFFSET : code;
            known = 1'b0;
            foreach (path_letters[i]) if (up == path_letters[i]) known = 1'b1;
         end while (known);
         offer_command(code, 1'b1, random_arg(), random_arg());
      end else begin
         offer_command($urandom_range(0, 1) ? LETTER_Z : LETTER_LC_Z, 1'b1);
         offer_command(8'($urandom), 1'b0, random_arg(), random_arg());
      end
      repeat (6) begin
         offer_command(path_letters[$urandom_range(0, 9)], 1'b1, random_arg(), random_arg(),
                       random_arg(), random_arg(), random_arg(), random_arg(), random_arg());
      end
   endtask

   always @(posedge clock) begin : response_sink
      path_command_type taken;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            taken.kind  = kind_type'(rsp_tuser[2:0]);
            taken.error = rsp_tuser[3];
            foreach (taken.v[i]) taken.v[i] = rsp_tdata[i * ArgWidth +: ArgWidth];
            tracker.check_response(taken);
            responses_taken++;
            if ($urandom_range(0, 29) == 0) sink_steady = !sink_steady;
            // One long hold-off lets the input side back up and stall.
            if (responses_taken == HOLD_AFTER) hold_left = HOLD_CYCLES;
            else stall_left = pick_gap(sink_steady);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("FAILURE");
      $finish;
   end

   initial begin
      tracker = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      drive_directed_path();
      drive_random_path(RANDOM_ITEMS);
      drive_failure_tail();
      req_tvalid <= 1'b0;
      while (tracker.pending_commands.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.pending_commands.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/vpcn_pkg.sv
rtl/vector_path_command_normalizer.sv
tb/sv/vector_path_command_normalizer_tb.sv
